@@ rtl/ids_pkg.sv @@
// Package for the include directive scanner.
// Holds scan modes, result kinds, character codes and the scan state record.
package ids_pkg;

  localparam int unsigned LenWidth = 13;
  localparam int unsigned CntWidth = 10;

  localparam logic [LenWidth-1:0] LEN_MAX = {LenWidth{1'b1}};

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [3:0] {
    MODE_NORMAL     = 4'd0,
    MODE_SLASH      = 4'd1,
    MODE_BLOCK      = 4'd2,
    MODE_BLOCK_STAR = 4'd3,
    MODE_LINE       = 4'd4,
    MODE_LITERAL    = 4'd5,
    MODE_ESCAPE     = 4'd6,
    MODE_KEYWORD    = 4'd7,
    MODE_KW_SPACE   = 4'd8,
    MODE_PATH       = 4'd9
  } scan_mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } result_kind_t;

  localparam int unsigned CfgPathLimit    = 0;
  localparam int unsigned CfgIncludeLimit = 1;

  typedef struct packed {
    scan_mode_t            scan_mode;
    logic                  literal_is_char;
    logic [2:0]            keyword_position;
    logic [LenWidth-1:0]   path_length;
    logic [CntWidth-1:0]   recorded_count;
    logic                  path_emitting;
  } scan_state_t;

  typedef struct packed {
    result_kind_t          kind;
    logic [7:0]            path_byte;
    logic                  path_kept;
    logic [CntWidth-1:0]   includes_found;
    logic                  unfinished_dropped;
  } scan_result_t;

  function automatic logic [7:0] keyword_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h23;
      3'd1:    c = 8'h69;
      3'd2:    c = 8'h6E;
      3'd3:    c = 8'h63;
      3'd4:    c = 8'h6C;
      3'd5:    c = 8'h75;
      3'd6:    c = 8'h64;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/ids_if.sv @@
// Stream interfaces of the include directive scanner: text in, results out.
// Depends on ids_pkg for field widths.
interface ids_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ids_result_if import ids_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          result_kind;
  logic [7:0]          path_byte;
  logic                path_kept;
  logic [CntWidth-1:0] includes_found;
  logic                unfinished_dropped;

  modport source (output valid, output result_kind, output path_byte, output path_kept,
                  output includes_found, output unfinished_dropped, input ready);
  modport sink   (input valid, input result_kind, input path_byte, input path_kept,
                  input includes_found, input unfinished_dropped, output ready);
endinterface

@@ rtl/ids_step.sv @@
// Next-state and result logic for one text byte of the include scanner.
// Depends on ids_pkg.
module ids_step import ids_pkg::*; (
  input  scan_state_t          state,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  input  logic [LenWidth-1:0]  path_length_limit,
  input  logic [CntWidth-1:0]  include_limit,
  output scan_state_t          state_next,
  output logic                 res_valid,
  output scan_result_t         res
);

  scan_mode_t  plain_mode;
  logic        plain_char;
  logic [2:0]  plain_kw;
  logic        below_limit;

  always_comb begin
    plain_mode = MODE_NORMAL;
    plain_char = state.literal_is_char;
    plain_kw   = 3'd0;
    case (text_byte)
      CH_SLASH: plain_mode = MODE_SLASH;
      CH_QUOTE: begin
        plain_mode = MODE_LITERAL;
        plain_char = 1'b0;
      end
      CH_APOS: begin
        plain_mode = MODE_LITERAL;
        plain_char = 1'b1;
      end
      CH_HASH: begin
        plain_mode = MODE_KEYWORD;
        plain_kw   = 3'd1;
      end
      default: plain_mode = MODE_NORMAL;
    endcase
  end

  assign below_limit = state.recorded_count < include_limit;

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res        = '{kind: KIND_BYTE, path_byte: 8'd0, path_kept: 1'b0,
                   includes_found: state.recorded_count, unfinished_dropped: 1'b0};

    if (end_of_text || text_byte == CH_NUL) begin
      res_valid                = 1'b1;
      res.kind                 = KIND_DONE;
      res.unfinished_dropped   = (state.scan_mode == MODE_PATH) && state.path_emitting;
      state_next               = '{scan_mode: MODE_NORMAL, literal_is_char: 1'b0,
                                   keyword_position: 3'd0, path_length: '0,
                                   recorded_count: '0, path_emitting: 1'b0};
    end else begin
      case (state.scan_mode)
        MODE_SLASH: begin
          if (text_byte == CH_STAR) begin
            state_next.scan_mode = MODE_BLOCK;
          end else if (text_byte == CH_SLASH) begin
            state_next.scan_mode = MODE_LINE;
          end else begin
            state_next.scan_mode        = plain_mode;
            state_next.literal_is_char  = plain_char;
            state_next.keyword_position = plain_kw;
          end
        end
        MODE_BLOCK: begin
          if (text_byte == CH_STAR) state_next.scan_mode = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (text_byte == CH_SLASH) begin
            state_next.scan_mode = MODE_NORMAL;
          end else if (text_byte != CH_STAR) begin
            state_next.scan_mode = MODE_BLOCK;
          end
        end
        MODE_LINE: begin
          if (text_byte == CH_NL) state_next.scan_mode = MODE_NORMAL;
        end
        MODE_LITERAL: begin
          if (text_byte == CH_BSLASH) begin
            state_next.scan_mode = MODE_ESCAPE;
          end else if (text_byte == (state.literal_is_char ? CH_APOS : CH_QUOTE)) begin
            state_next.scan_mode = MODE_NORMAL;
          end
        end
        MODE_ESCAPE: state_next.scan_mode = MODE_LITERAL;
        MODE_KEYWORD: begin
          if (text_byte == keyword_char(state.keyword_position)) begin
            if (state.keyword_position == 3'd7) begin
              state_next.scan_mode        = MODE_KW_SPACE;
              state_next.keyword_position = 3'd0;
            end else begin
              state_next.keyword_position = state.keyword_position + 3'd1;
            end
          end else begin
            state_next.scan_mode        = plain_mode;
            state_next.literal_is_char  = plain_char;
            state_next.keyword_position = plain_kw;
          end
        end
        MODE_KW_SPACE: begin
          if (text_byte == CH_QUOTE) begin
            state_next.scan_mode     = MODE_PATH;
            state_next.path_length   = '0;
            state_next.path_emitting = below_limit;
          end else if (text_byte != CH_SPACE && text_byte != CH_TAB) begin
            state_next.scan_mode        = plain_mode;
            state_next.literal_is_char  = plain_char;
            state_next.keyword_position = plain_kw;
          end
        end
        MODE_PATH: begin
          if (text_byte == CH_QUOTE) begin
            state_next.scan_mode     = MODE_NORMAL;
            state_next.path_length   = '0;
            state_next.path_emitting = 1'b0;
            res_valid                = state.path_emitting;
            res.kind                 = KIND_END;
            if (state.path_emitting && state.path_length < path_length_limit
                && below_limit) begin
              res.path_kept             = 1'b1;
              state_next.recorded_count = state.recorded_count + CntWidth'(1);
              res.includes_found        = state.recorded_count + CntWidth'(1);
            end
          end else begin
            if (state.path_length != LEN_MAX) begin
              state_next.path_length = state.path_length + LenWidth'(1);
            end
            res_valid     = state.path_emitting;
            res.kind      = KIND_BYTE;
            res.path_byte = text_byte;
          end
        end
        default: begin
          state_next.scan_mode        = plain_mode;
          state_next.literal_is_char  = plain_char;
          state_next.keyword_position = plain_kw;
        end
      endcase
    end
  end

endmodule

@@ rtl/include_directive_scanner.sv @@
// Top level of the include directive scanner: input register, scan state,
// output register and configuration registers. Depends on ids_pkg, ids_if, ids_step.
//
//  channel     | dir | transaction payload
//  ------------+-----+-----------------------------------------------------------
//  text_in     | in  | text_byte, end_of_text
//  result_out  | out | result_kind, path_byte, path_kept, includes_found,
//              |     | unfinished_dropped
//  write_*     | in  | write_index selects limit register, write_data value
//
// One byte per cycle unless a stalled result holds it: a byte waits in the
// input register, is scanned, and its result lands in the output register.
// A stalled result blocks only bytes that produce a result; bytes without a
// result keep flowing. Synchronous reset clears scan state and sets the
// limits to 256 and 64.
module include_directive_scanner import ids_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  ids_text_if.sink            text_in,
  ids_result_if.source        result_out,
  input  logic                write_enable,
  input  logic                write_index,
  input  logic [LenWidth-1:0] write_data
);

  logic                stage_valid;
  logic [7:0]          stage_byte;
  logic                stage_eot;
  logic                stage_adv;
  scan_state_t         state;
  scan_state_t         state_next;
  logic                res_valid;
  scan_result_t        res;
  logic                out_valid;
  scan_result_t        out_res;
  logic [LenWidth-1:0] path_length_limit;
  logic [CntWidth-1:0] include_limit;

  ids_step u_step (
    .state             (state),
    .text_byte         (stage_byte),
    .end_of_text       (stage_eot),
    .path_length_limit (path_length_limit),
    .include_limit     (include_limit),
    .state_next        (state_next),
    .res_valid         (res_valid),
    .res               (res)
  );

  assign stage_adv     = stage_valid && (!res_valid || !out_valid || result_out.ready);
  assign text_in.ready = !stage_valid || stage_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (text_in.ready) begin
      stage_valid <= text_in.valid;
    end
    if (text_in.ready && text_in.valid) begin
      stage_byte <= text_in.text_byte;
      stage_eot  <= text_in.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{scan_mode: MODE_NORMAL, literal_is_char: 1'b0, keyword_position: 3'd0,
                 path_length: '0, recorded_count: '0, path_emitting: 1'b0};
    end else if (stage_adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (stage_adv && res_valid) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_length_limit <= LenWidth'(256);
      include_limit     <= CntWidth'(64);
    end else if (write_enable) begin
      if (write_index == 1'(CfgPathLimit)) begin
        path_length_limit <= write_data;
      end else begin
        include_limit <= write_data[CntWidth-1:0];
      end
    end
  end

  assign result_out.valid              = out_valid;
  assign result_out.result_kind        = out_res.kind;
  assign result_out.path_byte          = out_res.path_byte;
  assign result_out.path_kept          = out_res.path_kept;
  assign result_out.includes_found     = out_res.includes_found;
  assign result_out.unfinished_dropped = out_res.unfinished_dropped;

  a_emit_in_path: assert property (@(posedge clk) disable iff (rst)
    state.path_emitting |-> state.scan_mode == MODE_PATH)
    else $error("path_emitting set outside a path");

  a_kw_in_keyword: assert property (@(posedge clk) disable iff (rst)
    state.keyword_position != 3'd0 |-> state.scan_mode == MODE_KEYWORD)
    else $error("keyword position set outside keyword match");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_out.ready && res_valid && stage_valid |=> $stable(state))
    else $error("scan state moved while its result was blocked");

  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == KIND_BYTE |-> !out_res.path_kept && !out_res.unfinished_dropped)
    else $error("path byte result carries end or done flags");

endmodule
